[design/verlet_particle_step_assert.svh]
// assertion macros for the particle step controller
// needs clk and rst_n in the scope where a macro is used
`ifndef VERLET_PARTICLE_STEP_ASSERT_SVH
`define VERLET_PARTICLE_STEP_ASSERT_SVH

// condition in the same cycle
`define VPS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// condition in the next cycle
`define VPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/vps_pkg.sv]
// shared types and constants of the particle step block
// no dependencies
package vps_pkg;

    localparam int DATA_W          = 32;
    localparam int FRAC            = 16;
    localparam int DT_W            = 16;
    localparam int ACT_W           = 2;
    localparam int CFG_ADDR_W      = 3;
    localparam int CAP_W           = 31;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int BOUNCE_AMOUNT_DEF = 65536;

    localparam int ITER_STEPS = 32;
    localparam int CNT_W      = $clog2(ITER_STEPS);

    localparam logic [1:0] AXIS_LAST = 2'd2;

    localparam logic [ACT_W-1:0] ACT_STEP      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_RESET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET_KEEP  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS_ON = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_X     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Y     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Z     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Z     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_CAP = 3'd7;

    typedef struct packed {
        logic       start;
        logic       vel;
        logic       sq;
        logic       cmp;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic       div_end;
        logic       acc1;
        logic       acc2;
        logic       acc3;
        logic       finish;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic limit;
        logic out_free;
    } dp_stat_t;

endpackage

[design/vps_ctrl.sv]
// sequencer of the particle step: walks axes and iteration counts
// depends on vps_pkg and verlet_particle_step_assert.svh
`include "verlet_particle_step_assert.svh"

module vps_ctrl
    import vps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [ACT_W-1:0] action,
    output logic             s_tready,
    input  dp_stat_t         stat,
    output dp_cmd_t          cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_VEL  = 11'b000_0000_0010,
        S_SQ   = 11'b000_0000_0100,
        S_CMP  = 11'b000_0000_1000,
        S_SQRT = 11'b000_0001_0000,
        S_DMUL = 11'b000_0010_0000,
        S_DIV  = 11'b000_0100_0000,
        S_DEND = 11'b000_1000_0000,
        S_ACC1 = 11'b001_0000_0000,
        S_ACC2 = 11'b010_0000_0000,
        S_ACC3 = 11'b100_0000_0000
    } state_t;

    // result handoff waits in S_IDLE with the done flag set, not in a state of its own
    localparam state_t S_DONE_UNUSED = S_IDLE;

    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    logic [1:0]       axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE) && !done_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        if (done_reg)
        begin
            // wait for the output slot
            if (stat.out_free)
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd.start = 1'b1;
                        axis_next = 2'd0;
                        if (action == ACT_STEP)
                            state_next = S_VEL;
                        else
                            done_next = 1'b1;
                    end
                end
                S_VEL:
                begin
                    cmd.vel = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_SQ;
                    end
                    else
                        axis_next = axis_reg + 2'd1;
                end
                S_SQ:
                begin
                    cmd.sq = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_CMP;
                    end
                    else
                        axis_next = axis_reg + 2'd1;
                end
                S_CMP:
                begin
                    cmd.cmp  = 1'b1;
                    cnt_next = '0;
                    state_next = stat.limit ? S_SQRT : S_ACC1;
                end
                S_SQRT:
                begin
                    cmd.sqrt_step = 1'b1;
                    if (cnt_reg == CNT_W'(ITER_STEPS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = S_DMUL;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                S_DMUL:
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                S_DIV:
                begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == CNT_W'(ITER_STEPS - 1))
                        state_next = S_DEND;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                S_DEND:
                begin
                    cmd.div_end = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_ACC1;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DMUL;
                    end
                end
                S_ACC1:
                begin
                    cmd.acc1   = 1'b1;
                    state_next = S_ACC2;
                end
                S_ACC2:
                begin
                    cmd.acc2   = 1'b1;
                    state_next = S_ACC3;
                end
                S_ACC3:
                begin
                    cmd.acc3 = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_DONE_UNUSED;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_ACC1;
                    end
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            axis_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    `VPS_ASSERT_NEXT(a_set_goes_done, accept && (action != ACT_STEP), done_reg)
    `VPS_ASSERT_SAME(a_axis_range, 1'b1, axis_reg != 2'd3)
    `VPS_ASSERT_SAME(a_finish_has_slot, cmd.finish, stat.out_free)

endmodule

[design/vps_dp.sv]
// datapath of the particle step: state, config, arithmetic, output register
// depends on vps_pkg
module vps_dp
    import vps_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int BOUNCE_AMOUNT = BOUNCE_AMOUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] load_x,
    input  logic signed [DATA_W-1:0] load_y,
    input  logic signed [DATA_W-1:0] load_z,
    input  logic signed [DATA_W-1:0] force_x,
    input  logic signed [DATA_W-1:0] force_y,
    input  logic signed [DATA_W-1:0] force_z,
    input  logic [DT_W-1:0]          time_step,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [DATA_W-1:0]        cfg_wdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] out_pos_x,
    output logic signed [DATA_W-1:0] out_pos_y,
    output logic signed [DATA_W-1:0] out_pos_z,
    output logic signed [DATA_W-1:0] out_vel_x,
    output logic signed [DATA_W-1:0] out_vel_y,
    output logic signed [DATA_W-1:0] out_vel_z,
    output logic                     speed_limited,
    output logic                     wall_hit
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = (CW + 8 > 52) ? CW + 8 : 52;
    localparam int FW = DATA_W + DT_W;
    localparam int A1W = DATA_W + 1;
    localparam int A2W = A1W + DT_W + 1;
    localparam int SW = 2 * DATA_W;
    localparam int PW = DATA_W + CAP_W;

    localparam logic signed [AW-1:0] CW_MAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] CW_MIN = ~CW_MAX;
    localparam logic signed [AW-1:0] D_MAX  = {{(AW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [AW-1:0] D_MIN  = ~D_MAX;
    localparam logic signed [AW-1:0] BOUNCE = AW'(BOUNCE_AMOUNT);
    localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (FRAC - 1);
    localparam logic [SW-1:0]        BIT_TOP = SW'(1) << (SW - 2);

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [AW-1:0] x);
        if (x > CW_MAX)
            return CW_MAX[CW-1:0];
        else if (x < CW_MIN)
            return CW_MIN[CW-1:0];
        else
            return x[CW-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [AW-1:0] x);
        if (x > D_MAX)
            return D_MAX[DATA_W-1:0];
        else if (x < D_MIN)
            return D_MIN[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [AW-1:0] ext_cw(input logic signed [CW-1:0] v);
        return {{(AW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [AW-1:0] ext_d(input logic signed [DATA_W-1:0] v);
        return {{(AW-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // state and configuration
    logic signed [CW-1:0]     pos_now_reg [3];
    logic signed [CW-1:0]     pos_prev_reg [3];
    logic                     bounds_on_reg;
    logic signed [DATA_W-1:0] box_min_reg [3];
    logic signed [DATA_W-1:0] box_max_reg [3];
    logic [CAP_W-1:0]         cap_reg;

    // per-item working registers
    logic signed [DATA_W-1:0] force_reg [3];
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] vel_reg [3];
    logic [SW-1:0]            sum_reg;
    logic                     limit_reg;
    logic                     hit_reg;
    logic [SW-1:0]            s_reg;
    logic [SW-1:0]            root_reg;
    logic [SW-1:0]            bit_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        lo_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic signed [FW-1:0]     fdt_reg;
    logic signed [A2W-1:0]    a2_reg;

    // output register
    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] opos_reg [3];
    logic signed [DATA_W-1:0] ovel_reg [3];
    logic                     olim_reg;
    logic                     ohit_reg;

    logic signed [DATA_W-1:0] load_in [3];
    logic signed [DATA_W-1:0] force_in [3];
    assign load_in  = '{load_x, load_y, load_z};
    assign force_in = '{force_x, force_y, force_z};

    logic [1:0]               ax;
    logic signed [AW-1:0]     now_w, prev_w, diff_w, damp_w, v_w;
    logic signed [DATA_W-1:0] vel_cur;
    logic [DATA_W-1:0]        mag;
    logic [SW-1:0]            sq_w;
    logic [2*CAP_W-1:0]       cap_sq;
    logic                     limit_w;
    logic [SW-1:0]            trial;
    logic                     sq_ge;
    logic [DATA_W-1:0]        len;
    logic [DATA_W:0]          dtrial;
    logic                     dge;
    logic [PW-1:0]            prod;
    logic signed [FW-1:0]     fdt_w;
    logic signed [AW-1:0]     a1_w;
    logic signed [A2W-1:0]    a2_w;
    logic signed [AW-1:0]     acc_w, psum_w, pw_w, min_w, max_w;
    logic signed [CW-1:0]     p_sat, p_new, b_new;
    logic                     hit_w;
    logic signed [DATA_W-1:0] qsigned;

    assign ax      = cmd.axis;
    assign now_w   = ext_cw(pos_now_reg[ax]);
    assign prev_w  = ext_cw(pos_prev_reg[ax]);
    // damping by 65470/65536
    assign diff_w  = now_w - prev_w;
    assign damp_w  = (diff_w <<< 6) + (diff_w <<< 1);
    assign v_w     = diff_w - ((damp_w + HALF) >>> FRAC);

    assign vel_cur = vel_reg[ax];
    assign mag     = vel_cur[DATA_W-1] ? DATA_W'(-vel_cur) : DATA_W'(vel_cur);
    assign sq_w    = mag * mag;
    assign cap_sq  = cap_reg * cap_reg;
    assign limit_w = (cap_reg != '0) && (sum_reg > SW'(cap_sq));

    // one bit of the square root per cycle
    assign trial   = root_reg + bit_reg;
    assign sq_ge   = s_reg >= trial;
    assign len     = root_reg[DATA_W-1:0];

    // restoring divide, quotient known to fit 32 bits
    assign prod    = mag * cap_reg;
    assign dtrial  = {rem_reg, lo_reg[DATA_W-1]};
    assign dge     = dtrial >= {1'b0, len};
    assign qsigned = vel_cur[DATA_W-1] ? -$signed(quo_reg) : $signed(quo_reg);

    // acceleration f*dt*dt with rounding after each product
    assign fdt_w   = force_reg[ax] * $signed({1'b0, dt_reg});
    assign a1_w    = (AW'(fdt_reg) + HALF) >>> FRAC;
    assign a2_w    = $signed(a1_w[A1W-1:0]) * $signed({1'b0, dt_reg});
    assign acc_w   = (AW'(a2_reg) + HALF) >>> FRAC;
    assign psum_w  = now_w + ext_d(vel_cur) + acc_w;
    assign p_sat   = sat_cw(psum_w);
    assign pw_w    = ext_cw(p_sat);
    assign min_w   = ext_d(box_min_reg[ax]);
    assign max_w   = ext_d(box_max_reg[ax]);

    always_comb
    begin
        p_new = p_sat;
        b_new = pos_now_reg[ax];
        hit_w = 1'b0;
        priority if (bounds_on_reg && (pw_w < min_w))
        begin
            p_new = sat_cw(min_w);
            b_new = sat_cw(min_w - BOUNCE);
            hit_w = 1'b1;
        end
        else if (bounds_on_reg && (pw_w > max_w))
        begin
            p_new = sat_cw(max_w);
            b_new = sat_cw(max_w + BOUNCE);
            hit_w = 1'b1;
        end
        else
        begin
            p_new = p_sat;
        end
    end

    assign stat.limit    = limit_w;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // configuration and particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_on_reg <= 1'b0;
            cap_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i]  <= D_MIN[DATA_W-1:0];
                box_max_reg[i]  <= D_MAX[DATA_W-1:0];
                pos_now_reg[i]  <= '0;
                pos_prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_BOUNDS_ON: bounds_on_reg  <= cfg_wdata[0];
                    REG_MIN_X:     box_min_reg[0] <= cfg_wdata;
                    REG_MIN_Y:     box_min_reg[1] <= cfg_wdata;
                    REG_MIN_Z:     box_min_reg[2] <= cfg_wdata;
                    REG_MAX_X:     box_max_reg[0] <= cfg_wdata;
                    REG_MAX_Y:     box_max_reg[1] <= cfg_wdata;
                    REG_MAX_Z:     box_max_reg[2] <= cfg_wdata;
                    REG_SPEED_CAP: cap_reg        <= cfg_wdata[CAP_W-1:0];
                endcase
            end
            if (cmd.start && ((action == ACT_SET_RESET) || (action == ACT_SET_KEEP)))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_now_reg[i]  <= sat_cw(ext_d(load_in[i]));
                    pos_prev_reg[i] <= (action == ACT_SET_RESET) ?
                                       sat_cw(ext_d(load_in[i])) : pos_now_reg[i];
                end
            end
            if (cmd.acc3)
            begin
                pos_now_reg[ax]  <= p_new;
                pos_prev_reg[ax] <= b_new;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dt_reg    <= time_step;
            sum_reg   <= '0;
            limit_reg <= 1'b0;
            hit_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                force_reg[i] <= force_in[i];
                vel_reg[i]   <= '0;
            end
        end
        if (cmd.vel)
            vel_reg[ax] <= sat_d(v_w);
        if (cmd.sq)
            sum_reg <= sum_reg + sq_w;
        if (cmd.cmp)
        begin
            limit_reg <= limit_w;
            s_reg     <= sum_reg;
            root_reg  <= '0;
            bit_reg   <= BIT_TOP;
        end
        if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                s_reg    <= s_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_load)
        begin
            rem_reg <= DATA_W'(prod[PW-1:DATA_W]);
            lo_reg  <= prod[DATA_W-1:0];
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= dge ? DATA_W'(dtrial - {1'b0, len}) : dtrial[DATA_W-1:0];
            lo_reg  <= lo_reg << 1;
            quo_reg <= {quo_reg[DATA_W-2:0], dge};
        end
        if (cmd.div_end)
            vel_reg[ax] <= qsigned;
        if (cmd.acc1)
            fdt_reg <= fdt_w;
        if (cmd.acc2)
            a2_reg <= a2_w;
        if (cmd.acc3 && hit_w)
            hit_reg <= 1'b1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                opos_reg[i] <= sat_d(ext_cw(pos_now_reg[i]));
                ovel_reg[i] <= vel_reg[i];
            end
            olim_reg <= limit_reg;
            ohit_reg <= hit_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign out_pos_x     = opos_reg[0];
    assign out_pos_y     = opos_reg[1];
    assign out_pos_z     = opos_reg[2];
    assign out_vel_x     = ovel_reg[0];
    assign out_vel_y     = ovel_reg[1];
    assign out_vel_z     = ovel_reg[2];
    assign speed_limited = olim_reg;
    assign wall_hit      = ohit_reg;

endmodule

[design/verlet_particle_step.sv]
// set and unused actions go straight to the output register; a step computes the
// velocities and their summed squares, compares them with the squared speed cap,
// runs the square root and a divide per axis when the cap clamps, then adds the
// acceleration to each position; the next item waits for the result handoff
// reset (rst_n, async low) zeroes the position history and loads register defaults
module verlet_particle_step
    import vps_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int BOUNCE_AMOUNT = BOUNCE_AMOUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_x, load_y, load_z, force_x, force_y, force_z, time_step
    input  logic [207:0]          s_tdata,
    // action
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    output logic [191:0]          m_tdata,
    // speed_limited, wall_hit
    output logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic signed [DATA_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic                     lim, hit;

    // controller: sequences velocity, clamp, acceleration per axis
    vps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: particle state, config registers, arithmetic, output register
    vps_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .BOUNCE_AMOUNT (BOUNCE_AMOUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (s_tuser),
        .load_x        (s_tdata[31:0]),
        .load_y        (s_tdata[63:32]),
        .load_z        (s_tdata[95:64]),
        .force_x       (s_tdata[127:96]),
        .force_y       (s_tdata[159:128]),
        .force_z       (s_tdata[191:160]),
        .time_step     (s_tdata[207:192]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_pos_x     (pos_x),
        .out_pos_y     (pos_y),
        .out_pos_z     (pos_z),
        .out_vel_x     (vel_x),
        .out_vel_y     (vel_y),
        .out_vel_z     (vel_z),
        .speed_limited (lim),
        .wall_hit      (hit)
    );

    // pack result item, first field lowest
    assign m_tdata = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
    assign m_tuser = {hit, lim};

endmodule

[tb/sv/verlet_particle_step_checker.sv]
// checker for the particle step block: watches config writes and both streams,
// predicts every result in fixed point and compares it with what the block sends
// depends on vps_pkg
module verlet_particle_step_checker
    import vps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [207:0]          s_tdata,
    input  logic [ACT_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [191:0]          m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [191:0] data;
        logic [1:0]   flags;
    } particle_out_t;

    particle_out_t       expected_q[$];
    logic                walls_on;
    logic signed [63:0]  wall_lo[3];
    logic signed [63:0]  wall_hi[3];
    logic [63:0]         cap;
    logic signed [63:0]  pos_now[3];
    logic signed [63:0]  pos_prev[3];

    function automatic logic signed [63:0] clip(input logic signed [63:0] x, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // round half up after dropping 16 fraction bits
    function automatic logic signed [63:0] round16(input logic signed [63:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic predict_particle(input logic [207:0] din, input logic [ACT_W-1:0] act);
        particle_out_t      r;
        logic signed [63:0] vel[3];
        logic signed [63:0] d;
        logic signed [63:0] f;
        logic signed [63:0] dt;
        logic signed [63:0] a;
        logic signed [63:0] p;
        logic signed [63:0] b;
        logic [63:0]        sum;
        logic [63:0]        mag;
        logic [63:0]        len;
        logic [63:0]        q;
        logic               limited;
        logic               hit;
        vel = '{64'sd0, 64'sd0, 64'sd0};
        limited = 1'b0;
        hit = 1'b0;
        sum = 0;
        if (act == ACT_SET_RESET || act == ACT_SET_KEEP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p = clip($signed(din[32*i +: 32]), COORD_WIDTH_DEF);
                pos_prev[i] = (act == ACT_SET_RESET) ? p : pos_now[i];
                pos_now[i] = p;
            end
        end
        else if (act == ACT_STEP)
        begin
            dt = {48'd0, din[207:192]};
            for (int i = 0; i < 3; i++)
            begin
                d = pos_now[i] - pos_prev[i];
                vel[i] = clip(d - round16(d * 64'sd66), 32);
                mag = (vel[i] < 0) ? -vel[i] : vel[i];
                sum = sum + mag * mag;
            end
            // length above the cap: rescale to the cap, truncating toward zero
            if (cap != 0 && sum > cap * cap)
            begin
                len = int_sqrt(sum);
                limited = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    mag = (vel[i] < 0) ? -vel[i] : vel[i];
                    q = (mag * cap) / len;
                    vel[i] = (vel[i] < 0) ? -$signed(q) : $signed(q);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                f = $signed(din[96 + 32*i +: 32]);
                a = round16(round16(f * dt) * dt);
                p = clip(pos_now[i] + vel[i] + a, COORD_WIDTH_DEF);
                b = pos_now[i];
                if (walls_on)
                begin
                    if (p < wall_lo[i])
                    begin
                        p = clip(wall_lo[i], COORD_WIDTH_DEF);
                        b = clip(wall_lo[i] - BOUNCE_AMOUNT_DEF, COORD_WIDTH_DEF);
                        hit = 1'b1;
                    end
                    else if (p > wall_hi[i])
                    begin
                        p = clip(wall_hi[i], COORD_WIDTH_DEF);
                        b = clip(wall_hi[i] + BOUNCE_AMOUNT_DEF, COORD_WIDTH_DEF);
                        hit = 1'b1;
                    end
                end
                pos_prev[i] = b;
                pos_now[i] = p;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r.data[32*i +: 32] = 32'(clip(pos_now[i], 32));
            r.data[96 + 32*i +: 32] = 32'(clip(vel[i], 32));
        end
        r.flags = {hit, limited};
        expected_q.push_back(r);
    endtask

    task automatic compare_particle();
        particle_out_t r;
        logic          bad;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item data=%h flags=%b", m_tdata, m_tuser);
            return;
        end
        r = expected_q.pop_front();
        bad = 1'b0;
        for (int k = 0; k < 6; k++)
            if (m_tdata[32*k +: 32] !== r.data[32*k +: 32])
            begin
                bad = 1'b1;
                if (errors < 10)
                    $display("field %0d: expected %h actual %h", k,
                             r.data[32*k +: 32], m_tdata[32*k +: 32]);
            end
        for (int k = 0; k < 2; k++)
            if (m_tuser[k] !== r.flags[k])
            begin
                bad = 1'b1;
                if (errors < 10)
                    $display("flag %0d: expected %b actual %b", k, r.flags[k], m_tuser[k]);
            end
        if (bad)
            errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walls_on = 1'b0;
            cap = 0;
            for (int i = 0; i < 3; i++)
            begin
                wall_lo[i] = -64'sd2147483648;
                wall_hi[i] = 64'sd2147483647;
                pos_now[i] = 0;
                pos_prev[i] = 0;
            end
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BOUNDS_ON: walls_on = cfg_wdata[0];
                    REG_MIN_X:     wall_lo[0] = $signed(cfg_wdata);
                    REG_MIN_Y:     wall_lo[1] = $signed(cfg_wdata);
                    REG_MIN_Z:     wall_lo[2] = $signed(cfg_wdata);
                    REG_MAX_X:     wall_hi[0] = $signed(cfg_wdata);
                    REG_MAX_Y:     wall_hi[1] = $signed(cfg_wdata);
                    REG_MAX_Z:     wall_hi[2] = $signed(cfg_wdata);
                    REG_SPEED_CAP: cap = {33'd0, cfg_wdata[CAP_W-1:0]};
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_particle(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                compare_particle();
            pending = expected_q.size();
        end
    end
endmodule

[tb/sv/verlet_particle_step_tb.sv]
// top of the particle step testbench: clock, reset, config writes, item stimulus,
// output back-pressure and the verdict; depends on vps_pkg, the block and its checker
module verlet_particle_step_tb;
    import vps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // load_x, load_y, load_z, force_x, force_y, force_z, time_step
    logic [207:0]          s_tdata;
    // action
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    logic [191:0]          m_tdata;
    // speed_limited, wall_hit
    logic [1:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wdata;
    int                    errors;
    int                    pending;
    logic                  calm;
    int                    quiet_cycles;

    verlet_particle_step u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    verlet_particle_step_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: cycles with no handshake on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, none once calm
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // mostly modest coordinates, now and then a full-range value
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_box(input logic [31:0] lo, input logic [31:0] hi);
        write_reg(REG_MIN_X, lo);
        write_reg(REG_MIN_Y, lo);
        write_reg(REG_MIN_Z, lo);
        write_reg(REG_MAX_X, hi);
        write_reg(REG_MAX_Y, hi);
        write_reg(REG_MAX_Z, hi);
    endtask

    // entered and left at a falling edge
    task automatic send_particle(input logic [ACT_W-1:0] act, input logic [95:0] ld,
                                 input logic [95:0] fr, input logic [15:0] dt);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = {dt, fr, ld};
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_random();
        logic [ACT_W-1:0] act;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 62)
            act = ACT_STEP;
        else if (r < 78)
            act = ACT_SET_RESET;
        else if (r < 95)
            act = ACT_SET_KEEP;
        else
            act = ACT_UNUSED;
        send_particle(act, {rand_coord(), rand_coord(), rand_coord()},
                      {rand_coord(), rand_coord(), rand_coord()},
                      16'(($urandom_range(0, 2) == 0) ? $urandom
                                                      : $urandom_range(0, 16'h0800)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_STEP;
        cfg_we = 1'b0;
        cfg_addr = REG_BOUNDS_ON;
        cfg_wdata = '0;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset defaults, extremes of loads, forces and time step
        send_particle(ACT_STEP, '0, '0, 16'd0);
        send_particle(ACT_SET_RESET, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000}, '0, 16'd0);
        send_particle(ACT_SET_KEEP, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000}, '0, 16'd0);
        send_particle(ACT_STEP, '0, {3{32'h7FFF_FFFF}}, 16'hFFFF);
        send_particle(ACT_STEP, '0, {3{32'h8000_0000}}, 16'hFFFF);
        send_particle(ACT_UNUSED, {3{32'h1234_5678}}, '0, 16'd0);
        send_particle(ACT_STEP, '0, {32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000}, 16'h8000);
        drain();
        // speed cap clamps, box wall hits on both sides and bounce saturation
        write_reg(REG_BOUNDS_ON, 32'd1);
        write_reg(REG_SPEED_CAP, 32'h0002_0000);
        set_box(32'hFFF0_0000, 32'h0010_0000);
        send_particle(ACT_SET_RESET, {3{32'h0000_0000}}, '0, 16'd0);
        send_particle(ACT_SET_KEEP, {32'h0008_0000, 32'hFFF8_0000, 32'h0000_1000}, '0, 16'd0);
        send_particle(ACT_STEP, '0, '0, 16'd0);
        send_particle(ACT_STEP, '0, {3{32'h7FFF_FFFF}}, 16'hFFFF);
        send_particle(ACT_STEP, '0, {3{32'h8000_0000}}, 16'hFFFF);
        drain();
        // lower bound above upper, extreme box edges, widest cap
        set_box(32'h0010_0000, 32'hFFF0_0000);
        write_reg(REG_SPEED_CAP, 32'h7FFF_FFFF);
        send_particle(ACT_SET_RESET, {3{32'h0000_0000}}, '0, 16'd0);
        send_particle(ACT_STEP, '0, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 16'hFFFF);
        drain();
        set_box(32'h8000_0000, 32'h7FFF_FFFF);
        send_particle(ACT_SET_RESET, {3{32'h7FFF_0000}}, '0, 16'd0);
        send_particle(ACT_SET_KEEP, {3{32'h8000_0000}}, '0, 16'd0);
        send_particle(ACT_STEP, '0, {3{32'h8000_0000}}, 16'hFFFF);
        send_particle(ACT_SET_KEEP, {3{32'h7FFF_FFFF}}, '0, 16'd0);
        send_particle(ACT_STEP, '0, {3{32'h7FFF_FFFF}}, 16'hFFFF);
        drain();

        // random phases, each with its own register setting; sender waits for drain
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 8)
                calm = 1'b1;
            drain();
            write_reg(REG_BOUNDS_ON, $urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: write_reg(REG_SPEED_CAP, 32'd0);
                1: write_reg(REG_SPEED_CAP, $urandom);
                default: write_reg(REG_SPEED_CAP, $urandom_range(1, 32'h0040_0000));
            endcase
            for (int k = 0; k < 6; k++)
                write_reg(CFG_ADDR_W'(REG_MIN_X + k),
                          (k < 3) ? ($urandom_range(0, 32'h0080_0000) - 32'h0090_0000)
                                  : ($urandom_range(0, 32'h0090_0000) - 32'h0010_0000));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_ADDR_W'(REG_MIN_X + $urandom_range(0, 5)), $urandom);
            for (int n = 0; n < 150; n++)
                send_random();
        end
        s_tvalid = 1'b0;

        drain();
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
